// ===== rtl/bcx_pkg.sv =====
// ----------------------------------------------------------------------------
// Binary conv1d package
// Shared types and constants of the XNOR-popcount convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package bcx_pkg;

   localparam int MAX_IN_CHANNELS_DEF  = 64;
   localparam int MAX_KERNEL_DEF       = 8;
   localparam int MAX_OUT_CHANNELS_DEF = 64;
   localparam int WEIGHT_WORDS_DEF     = 1024;
   localparam int INPUT_WORDS_DEF      = 32;

   localparam logic [2:0] REG_IN_CHANNELS  = 3'd0;
   localparam logic [2:0] REG_KERNEL_SIZE  = 3'd1;
   localparam logic [2:0] REG_OUT_CHANNELS = 3'd2;
   localparam logic [2:0] REG_IN_OFFSET    = 3'd3;
   localparam logic [2:0] REG_OUT_OFFSET   = 3'd4;

   localparam logic [31:0] BIT_MSB  = 32'h8000_0000;
   localparam logic [4:0]  BIT_LAST = 5'h1F;

   typedef enum logic [1:0] {
      OP_LOAD_WEIGHT = 2'd0,
      OP_LOAD_INPUT  = 2'd1,
      OP_LOAD_THRESH = 2'd2,
      OP_RUN         = 2'd3
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [9:0]  index;
      logic [31:0] data_word;
      logic [15:0] threshold;
   } item_type;

   typedef struct packed {
      logic [6:0] in_channels;
      logic [3:0] kernel_steps;
      logic [6:0] out_channels;
      logic [4:0] input_bit_offset;
      logic [4:0] output_bit_offset;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_PREP,
      ST_CELL,
      ST_BITS,
      ST_WAIT,
      ST_DECIDE
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/bcx_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bcx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/bcx_front.sv =====
// ----------------------------------------------------------------------------
// Binary conv1d front end
// Accepts request beats into a two-entry queue for the execution engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bcx_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire bcx_pkg::item_type in_item,
   output logic                   item_valid,
   output bcx_pkg::item_type      item,
   input  wire logic              item_pop
);

   bcx_pkg::item_type q_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready   = (cnt_ff != 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rp_ff];
   assign push       = in_valid && in_ready;
   assign pop        = item_pop && item_valid;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wp_ff] <= in_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bcx_back.sv =====
// ----------------------------------------------------------------------------
// Binary conv1d execution engine
// Writes the stores and walks the kernel bits of each output cell.
// ----------------------------------------------------------------------------
`default_nettype none

module bcx_back #(
   parameter int MAX_IN_CHANNELS  = bcx_pkg::MAX_IN_CHANNELS_DEF,
   parameter int MAX_KERNEL       = bcx_pkg::MAX_KERNEL_DEF,
   parameter int MAX_OUT_CHANNELS = bcx_pkg::MAX_OUT_CHANNELS_DEF,
   parameter int WEIGHT_WORDS     = bcx_pkg::WEIGHT_WORDS_DEF,
   parameter int INPUT_WORDS      = bcx_pkg::INPUT_WORDS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bcx_pkg::cfg_type  cfg,
   input  wire logic              item_valid,
   input  wire bcx_pkg::item_type item,
   output logic                   item_pop,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [3:0]             out_word_index,
   output logic [31:0]            out_bits,
   output logic [31:0]            out_bmask,
   output logic                   out_last
);

   localparam int ICW = $clog2(MAX_IN_CHANNELS + 1);
   localparam int KSW = $clog2(MAX_KERNEL + 1);
   localparam int OCW = $clog2(MAX_OUT_CHANNELS + 1);
   localparam int OIW = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
   localparam int CW  = $clog2(MAX_IN_CHANNELS * MAX_KERNEL + 1);
   localparam int WPW = $clog2(MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL + 1);
   localparam int IPW = $clog2(32 + 4 * MAX_IN_CHANNELS + MAX_IN_CHANNELS * MAX_KERNEL);
   localparam int OPW = $clog2(32 + 4 * MAX_OUT_CHANNELS + 1);
   localparam int WAW = (WEIGHT_WORDS > 1) ? $clog2(WEIGHT_WORDS) : 1;
   localparam int IAW = (INPUT_WORDS > 1) ? $clog2(INPUT_WORDS) : 1;

   bcx_pkg::state_type state_ff, state_in;

   logic [ICW-1:0] ic_ff, ic_in;
   logic [KSW-1:0] ks_ff, ks_in;
   logic [OCW-1:0] oc_ff, oc_in, o_ff, o_in;
   logic [CW-1:0]  k_ff, k_in, i_ff, i_in, count_ff, count_in;
   logic [1:0]     t_ff, t_in;
   logic [WPW-1:0] wpos_ff, wpos_in;
   logic [IPW-1:0] ibase_ff, ibase_in, ipos_ff, ipos_in;
   logic [OPW-1:0] pos_ff, pos_in;
   logic [31:0]    acc_bits_ff, acc_bits_in, acc_mask_ff, acc_mask_in;
   logic           pipe_vld_ff;
   logic [4:0]     sel_w_ff, sel_i_ff;
   logic           ov_ff, ov_in, olast_ff, olast_in;
   logic [3:0]     oidx_ff, oidx_in;
   logic [31:0]    obits_ff, obits_in, omask_ff, omask_in;

   logic [WPW+WAW:0] wpos_ext;
   logic [IPW+IAW:0] ipos_ext;
   logic [31:0]      w_rd, i_rd, cur_mask;
   logic [15:0]      thr_rd;
   logic             w_we, i_we, t_we, last_cell, emit, hit, can_load;

   assign wpos_ext = (WPW + WAW + 1)'(wpos_ff);
   assign ipos_ext = (IPW + IAW + 1)'(ipos_ff);

   assign w_we = (state_ff == bcx_pkg::ST_IDLE) && item_valid
                 && (item.op == bcx_pkg::OP_LOAD_WEIGHT) && (32'(item.index) < WEIGHT_WORDS);
   assign i_we = (state_ff == bcx_pkg::ST_IDLE) && item_valid
                 && (item.op == bcx_pkg::OP_LOAD_INPUT) && (32'(item.index) < INPUT_WORDS);
   assign t_we = (state_ff == bcx_pkg::ST_IDLE) && item_valid
                 && (item.op == bcx_pkg::OP_LOAD_THRESH)
                 && (32'(item.index) < MAX_OUT_CHANNELS);
   assign item_pop = (state_ff == bcx_pkg::ST_IDLE);

   bcx_ram #(.WIDTH(32), .DEPTH(WEIGHT_WORDS)) u_wgt (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (item.index[WAW-1:0]),
      .wr_data (item.data_word),
      .rd_addr (wpos_ext[5 +: WAW]),
      .rd_data (w_rd)
   );

   bcx_ram #(.WIDTH(32), .DEPTH(INPUT_WORDS)) u_inp (
      .clock   (clock),
      .wr_en   (i_we),
      .wr_addr (item.index[IAW-1:0]),
      .wr_data (item.data_word),
      .rd_addr (ipos_ext[5 +: IAW]),
      .rd_data (i_rd)
   );

   bcx_ram #(.WIDTH(16), .DEPTH(MAX_OUT_CHANNELS)) u_thr (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (item.index[OIW-1:0]),
      .wr_data (item.threshold),
      .rd_addr (o_ff[OIW-1:0]),
      .rd_data (thr_rd)
   );

   assign last_cell = (t_ff == 2'd3) && (o_ff == oc_ff - OCW'(1));
   assign emit      = (pos_ff[4:0] == bcx_pkg::BIT_LAST) || last_cell;
   assign hit       = $signed({1'b0, count_ff}) >= $signed(thr_rd);
   assign can_load  = !ov_ff || out_ready;
   assign cur_mask  = bcx_pkg::BIT_MSB >> pos_ff[4:0];

   always_comb begin
      state_in    = state_ff;
      ic_in       = ic_ff;
      ks_in       = ks_ff;
      oc_in       = oc_ff;
      k_in        = k_ff;
      o_in        = o_ff;
      t_in        = t_ff;
      i_in        = i_ff;
      wpos_in     = wpos_ff;
      ibase_in    = ibase_ff;
      ipos_in     = ipos_ff;
      pos_in      = pos_ff;
      acc_bits_in = acc_bits_ff;
      acc_mask_in = acc_mask_ff;
      count_in    = count_ff;
      ov_in       = ov_ff && !out_ready;
      oidx_in     = oidx_ff;
      obits_in    = obits_ff;
      omask_in    = omask_ff;
      olast_in    = olast_ff;
      if (pipe_vld_ff) begin
         count_in = count_ff
                    + {{(CW-1){1'b0}}, w_rd[5'd31 - sel_w_ff] ~^ i_rd[5'd31 - sel_i_ff]};
      end
      case (state_ff)
         bcx_pkg::ST_IDLE: begin
            if (item_valid && item.op == bcx_pkg::OP_RUN) begin
               state_in = bcx_pkg::ST_SETUP;
            end
         end
         bcx_pkg::ST_SETUP: begin
            ic_in = (32'(cfg.in_channels) > MAX_IN_CHANNELS) ?
                    ICW'(MAX_IN_CHANNELS) : ICW'(cfg.in_channels);
            ks_in = (32'(cfg.kernel_steps) > MAX_KERNEL) ?
                    KSW'(MAX_KERNEL) : KSW'(cfg.kernel_steps);
            oc_in = (32'(cfg.out_channels) > MAX_OUT_CHANNELS) ?
                    OCW'(MAX_OUT_CHANNELS) : OCW'(cfg.out_channels);
            state_in = bcx_pkg::ST_PREP;
         end
         bcx_pkg::ST_PREP: begin
            k_in        = CW'(ic_ff * ks_ff);
            t_in        = 2'd0;
            o_in        = '0;
            wpos_in     = '0;
            ibase_in    = IPW'(cfg.input_bit_offset);
            pos_in      = OPW'(cfg.output_bit_offset);
            acc_bits_in = '0;
            acc_mask_in = '0;
            state_in    = (oc_ff == '0) ? bcx_pkg::ST_IDLE : bcx_pkg::ST_CELL;
         end
         bcx_pkg::ST_CELL: begin
            i_in     = '0;
            ipos_in  = ibase_ff;
            count_in = '0;
            state_in = (k_ff == '0) ? bcx_pkg::ST_WAIT : bcx_pkg::ST_BITS;
         end
         bcx_pkg::ST_BITS: begin
            wpos_in = wpos_ff + WPW'(1);
            ipos_in = ipos_ff + IPW'(1);
            i_in    = i_ff + CW'(1);
            if (i_ff + CW'(1) == k_ff) begin
               state_in = bcx_pkg::ST_WAIT;
            end
         end
         bcx_pkg::ST_WAIT: begin
            state_in = bcx_pkg::ST_DECIDE;
         end
         bcx_pkg::ST_DECIDE: begin
            if (!emit || can_load) begin
               acc_bits_in = acc_bits_ff | (hit ? cur_mask : 32'd0);
               acc_mask_in = acc_mask_ff | cur_mask;
               if (emit) begin
                  ov_in       = 1'b1;
                  oidx_in     = pos_ff[5 +: 4];
                  obits_in    = acc_bits_in;
                  omask_in    = acc_mask_in;
                  olast_in    = last_cell;
                  acc_bits_in = '0;
                  acc_mask_in = '0;
               end
               pos_in = pos_ff + OPW'(1);
               if (last_cell) begin
                  state_in = bcx_pkg::ST_IDLE;
               end else begin
                  state_in = bcx_pkg::ST_CELL;
                  if (o_ff == oc_ff - OCW'(1)) begin
                     o_in     = '0;
                     t_in     = t_ff + 2'd1;
                     wpos_in  = '0;
                     ibase_in = ibase_ff + IPW'(ic_ff);
                  end else begin
                     o_in = o_ff + OCW'(1);
                  end
               end
            end
         end
         default: begin
            state_in = bcx_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= bcx_pkg::ST_IDLE;
         ov_ff       <= 1'b0;
         pipe_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ov_ff       <= ov_in;
         pipe_vld_ff <= (state_ff == bcx_pkg::ST_BITS);
      end
      ic_ff       <= ic_in;
      ks_ff       <= ks_in;
      oc_ff       <= oc_in;
      k_ff        <= k_in;
      o_ff        <= o_in;
      t_ff        <= t_in;
      i_ff        <= i_in;
      wpos_ff     <= wpos_in;
      ibase_ff    <= ibase_in;
      ipos_ff     <= ipos_in;
      pos_ff      <= pos_in;
      acc_bits_ff <= acc_bits_in;
      acc_mask_ff <= acc_mask_in;
      count_ff    <= count_in;
      sel_w_ff    <= wpos_ff[4:0];
      sel_i_ff    <= ipos_ff[4:0];
      oidx_ff     <= oidx_in;
      obits_ff    <= obits_in;
      omask_ff    <= omask_in;
      olast_ff    <= olast_in;
   end

   assign out_valid      = ov_ff;
   assign out_word_index = oidx_ff;
   assign out_bits       = obits_ff;
   assign out_bmask      = omask_ff;
   assign out_last       = olast_ff;

endmodule

`default_nettype wire

// ===== rtl/binary_conv1d_xnor_popcount.sv =====
// ----------------------------------------------------------------------------
// Binary conv1d XNOR-popcount layer
// Loads weights, inputs and thresholds, then emits packed binary results.
// ----------------------------------------------------------------------------
// Load beats are queued ahead of the engine, which takes them only while idle.
// A run beat walks every kernel bit of each of the 4*out_channels cells one bit
// per cycle through the store read ports; the request side stays open while
// the two-entry queue has room.
`default_nettype none

module binary_conv1d_xnor_popcount #(
   parameter int MAX_IN_CHANNELS  = bcx_pkg::MAX_IN_CHANNELS_DEF,
   parameter int MAX_KERNEL       = bcx_pkg::MAX_KERNEL_DEF,
   parameter int MAX_OUT_CHANNELS = bcx_pkg::MAX_OUT_CHANNELS_DEF,
   parameter int WEIGHT_WORDS     = bcx_pkg::WEIGHT_WORDS_DEF,
   parameter int INPUT_WORDS      = bcx_pkg::INPUT_WORDS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // op[1:0]
   input  wire logic [1:0]  req_tuser,
   // index[9:0], data_word[41:10], threshold[57:42], zero[63:58]
   input  wire logic [63:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // word_index[3:0], out_bits[35:4], bit_mask[67:36], zero[71:68]
   output logic [71:0]      rsp_tdata,
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [6:0]  csr_data
);

   bcx_pkg::cfg_type  cfg_ff;
   bcx_pkg::item_type in_item, item;
   logic              item_valid, item_pop;
   logic [3:0]        widx;
   logic [31:0]       obits, omask;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_channels       <= 7'd1;
         cfg_ff.kernel_steps      <= 4'd1;
         cfg_ff.out_channels      <= 7'd1;
         cfg_ff.input_bit_offset  <= 5'd0;
         cfg_ff.output_bit_offset <= 5'd0;
      end else if (csr_valid) begin
         case (csr_index)
            bcx_pkg::REG_IN_CHANNELS:  cfg_ff.in_channels       <= csr_data;
            bcx_pkg::REG_KERNEL_SIZE:  cfg_ff.kernel_steps      <= csr_data[3:0];
            bcx_pkg::REG_OUT_CHANNELS: cfg_ff.out_channels      <= csr_data;
            bcx_pkg::REG_IN_OFFSET:    cfg_ff.input_bit_offset  <= csr_data[4:0];
            bcx_pkg::REG_OUT_OFFSET:   cfg_ff.output_bit_offset <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   assign in_item.op        = bcx_pkg::op_type'(req_tuser);
   assign in_item.index     = req_tdata[9:0];
   assign in_item.data_word = req_tdata[41:10];
   assign in_item.threshold = req_tdata[57:42];

   bcx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   bcx_back #(
      .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
      .MAX_KERNEL       (MAX_KERNEL),
      .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS),
      .WEIGHT_WORDS     (WEIGHT_WORDS),
      .INPUT_WORDS      (INPUT_WORDS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .item_valid     (item_valid),
      .item           (item),
      .item_pop       (item_pop),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_word_index (widx),
      .out_bits       (obits),
      .out_bmask      (omask),
      .out_last       (rsp_tlast)
   );

   assign rsp_tdata = {4'd0, omask, obits, widx};

endmodule

`default_nettype wire

// ===== rtl/bcx_checker.sv =====
// ----------------------------------------------------------------------------
// Binary conv1d port checker
// Checks result beats seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module bcx_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [71:0] rsp_tdata
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("Result beat dropped while stalled.");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result beat present after reset.");

   a_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[67:36] != 32'd0)
      else $error("Result beat with empty mask.");

   a_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[35:4] & ~rsp_tdata[67:36]) == 32'd0)
      else $error("Result bits outside the mask.");

endmodule

bind binary_conv1d_xnor_popcount bcx_checker u_bcx_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== test/binary_conv1d_xnor_popcount_tb.sv =====
// ----------------------------------------------------------------------------
// Binary conv1d XNOR-popcount testbench
// Preloads the store entries that runs read, then drives directed and random
// load and run beats under several idle patterns and register settings. A
// scoreboard keeps its own copy of the stores and registers, predicts each
// packed result word of a run and checks the result beats against it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module binary_conv1d_xnor_popcount_tb;

   localparam int PRE_WEIGHTS = 8;
   localparam int PRE_INPUTS  = 10;
   localparam int PRE_THRESH  = 16;

   localparam logic [2:0] REG_SPARE_A = 3'd5;
   localparam logic [2:0] REG_SPARE_B = 3'd7;

   typedef struct {
      logic [3:0]  word_index;
      logic [31:0] out_bits;
      logic [31:0] bit_mask;
      logic        last;
   } result_word_type;

   class conv_scoreboard;
      logic [31:0]        weight_mem[bcx_pkg::WEIGHT_WORDS_DEF];
      logic [31:0]        input_mem[bcx_pkg::INPUT_WORDS_DEF];
      logic signed [15:0] thresh_mem[bcx_pkg::MAX_OUT_CHANNELS_DEF];
      logic [6:0]         in_ch;
      logic [3:0]         kern;
      logic [6:0]         out_ch;
      logic [4:0]         in_off;
      logic [4:0]         out_off;
      result_word_type    expected_words[$];
      int                 errors;

      function new();
         in_ch = 1;
         kern = 1;
         out_ch = 1;
         in_off = 0;
         out_off = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [6:0] val);
         case (idx)
            bcx_pkg::REG_IN_CHANNELS: in_ch = val;
            bcx_pkg::REG_KERNEL_SIZE: kern = val[3:0];
            bcx_pkg::REG_OUT_CHANNELS: out_ch = val;
            bcx_pkg::REG_IN_OFFSET: in_off = val[4:0];
            bcx_pkg::REG_OUT_OFFSET: out_off = val[4:0];
            default: ;
         endcase
      endfunction

      function void note_item(bcx_pkg::item_type it);
         int ic, ks, oc, k, count, pos, lastw;
         logic [31:0] words[9];
         logic [31:0] masks[9];
         logic a, b;
         result_word_type rw;
         case (it.op)
            bcx_pkg::OP_LOAD_WEIGHT: weight_mem[it.index] = it.data_word;
            bcx_pkg::OP_LOAD_INPUT: begin
               if (it.index < bcx_pkg::INPUT_WORDS_DEF) input_mem[it.index] = it.data_word;
            end
            bcx_pkg::OP_LOAD_THRESH: begin
               if (it.index < bcx_pkg::MAX_OUT_CHANNELS_DEF) thresh_mem[it.index] = it.threshold;
            end
            default: begin
               ic = (in_ch > bcx_pkg::MAX_IN_CHANNELS_DEF) ? bcx_pkg::MAX_IN_CHANNELS_DEF : in_ch;
               ks = (kern > bcx_pkg::MAX_KERNEL_DEF) ? bcx_pkg::MAX_KERNEL_DEF : kern;
               oc = (out_ch > bcx_pkg::MAX_OUT_CHANNELS_DEF) ?
                    bcx_pkg::MAX_OUT_CHANNELS_DEF : out_ch;
               k = ic * ks;
               if (oc == 0) return;
               for (int i = 0; i < 9; i++) begin
                  words[i] = '0;
                  masks[i] = '0;
               end
               for (int t = 0; t < 4; t++) begin
                  for (int o = 0; o < oc; o++) begin
                     count = 0;
                     for (int i = 0; i < k; i++) begin
                        pos = o * k + i;
                        a = weight_mem[(pos >> 5) % bcx_pkg::WEIGHT_WORDS_DEF][31 - (pos & 31)];
                        pos = in_off + t * ic + i;
                        b = input_mem[(pos >> 5) % bcx_pkg::INPUT_WORDS_DEF][31 - (pos & 31)];
                        count += (a == b);
                     end
                     pos = out_off + t * oc + o;
                     masks[pos >> 5] |= bcx_pkg::BIT_MSB >> (pos & 31);
                     if (count >= int'(thresh_mem[o]))
                        words[pos >> 5] |= bcx_pkg::BIT_MSB >> (pos & 31);
                  end
               end
               lastw = (out_off + 4 * oc - 1) >> 5;
               for (int i = 0; i <= lastw; i++) begin
                  rw.word_index = i[3:0];
                  rw.out_bits = words[i];
                  rw.bit_mask = masks[i];
                  rw.last = (i == lastw);
                  expected_words.push_back(rw);
               end
            end
         endcase
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      task check_result(logic [71:0] tdata, logic tlast);
         result_word_type rw;
         if (expected_words.size() == 0) begin
            report($sformatf("unexpected result beat %h", tdata));
            return;
         end
         rw = expected_words.pop_front();
         if (tdata[3:0] !== rw.word_index)
            report($sformatf("word_index %0d, expected %0d", tdata[3:0], rw.word_index));
         if (tdata[35:4] !== rw.out_bits)
            report($sformatf("out_bits %h, expected %h", tdata[35:4], rw.out_bits));
         if (tdata[67:36] !== rw.bit_mask)
            report($sformatf("bit_mask %h, expected %h", tdata[67:36], rw.bit_mask));
         if (tlast !== rw.last)
            report($sformatf("last %b, expected %b", tlast, rw.last));
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [6:0]  csr_data = '0;

   logic sender_idles = 0;
   logic receiver_stalls = 0;
   int   idle_pct = 81;

   conv_scoreboard sb = new();

   binary_conv1d_xnor_popcount dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
      rsp_tready <= receiver_stalls ? ($urandom % 100 >= idle_pct) : 1'b1;
   end

   task automatic send_beat(bcx_pkg::op_type op, int idx, logic [31:0] data,
                            logic [15:0] thr);
      bcx_pkg::item_type it;
      it.op = op;
      it.index = idx[9:0];
      it.data_word = data;
      it.threshold = thr;
      if (sender_idles && ($urandom % 100 < idle_pct)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom % 100 < idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.op;
      req_tdata <= {6'b0, it.threshold, it.data_word, it.index};
      do @(posedge clock); while (!req_tready);
      sb.note_item(it);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [6:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      csr_valid <= 1'b0;
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_config(int ic, int ks, int oc, int ioff, int ooff);
      drain();
      write_csr(bcx_pkg::REG_IN_CHANNELS, ic[6:0]);
      write_csr(bcx_pkg::REG_KERNEL_SIZE, ks[6:0]);
      write_csr(bcx_pkg::REG_OUT_CHANNELS, oc[6:0]);
      write_csr(bcx_pkg::REG_IN_OFFSET, ioff[6:0]);
      write_csr(bcx_pkg::REG_OUT_OFFSET, ooff[6:0]);
      csr_valid <= 1'b0;
   endtask

   task automatic random_beat(int k);
      int r;
      logic [15:0] thr;
      r = int'($urandom % 100);
      if (r < 20) begin
         send_beat(bcx_pkg::OP_LOAD_WEIGHT, $urandom_range(0, 1023), $urandom, 16'($urandom));
      end else if (r < 40) begin
         send_beat(bcx_pkg::OP_LOAD_INPUT, $urandom_range(0, 40), $urandom, 16'($urandom));
      end else if (r < 60) begin
         thr = ($urandom % 4 == 0) ? 16'($urandom) : 16'($urandom_range(0, k + 4) - 2);
         send_beat(bcx_pkg::OP_LOAD_THRESH, $urandom_range(0, 72), $urandom, thr);
      end else begin
         send_beat(bcx_pkg::OP_RUN, $urandom_range(0, 1023), $urandom, 16'($urandom));
      end
   endtask

   initial begin
      int ic, ks, oc;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Runs below never reach past these preloaded store entries.
      for (int i = 0; i < PRE_WEIGHTS; i++)
         send_beat(bcx_pkg::OP_LOAD_WEIGHT, i,
                   (i % 3 == 0) ? 32'hFFFF_FFFF : 32'($urandom), '0);
      for (int i = 0; i < PRE_INPUTS; i++)
         send_beat(bcx_pkg::OP_LOAD_INPUT, i, (i == 3) ? 32'h0 : 32'($urandom), '0);
      for (int i = 0; i < PRE_THRESH; i++)
         send_beat(bcx_pkg::OP_LOAD_THRESH, i, '0, 16'($urandom_range(0, 3)));

      send_beat(bcx_pkg::OP_RUN, 0, '0, '0);
      send_beat(bcx_pkg::OP_LOAD_THRESH, 0, '0, 16'h8000);
      send_beat(bcx_pkg::OP_LOAD_THRESH, 1, '0, 16'h7FFF);
      send_beat(bcx_pkg::OP_LOAD_THRESH, 64, '0, 16'h1234);
      send_beat(bcx_pkg::OP_LOAD_THRESH, 1023, '0, 16'h0);
      send_beat(bcx_pkg::OP_LOAD_INPUT, 1023, 32'hDEAD_BEEF, '0);
      send_beat(bcx_pkg::OP_LOAD_WEIGHT, 1023, 32'hFFFF_FFFF, 16'hFFFF);
      send_beat(bcx_pkg::OP_RUN, 1023, 32'hFFFF_FFFF, 16'hFFFF);

      set_config(0, 0, 3, 5, 7);
      send_beat(bcx_pkg::OP_RUN, 0, '0, '0);
      set_config(2, 3, 0, 0, 0);
      send_beat(bcx_pkg::OP_RUN, 0, '0, '0);
      drain();
      write_csr(REG_SPARE_A, 7'h7F);
      write_csr(REG_SPARE_B, 7'h1);
      set_config(3, 2, 9, 31, 31);
      send_beat(bcx_pkg::OP_RUN, 0, '0, '0);
      set_config(127, 1, 1, 31, 31);
      send_beat(bcx_pkg::OP_RUN, 0, '0, '0);
      set_config(3, 15, 10, 17, 29);
      send_beat(bcx_pkg::OP_RUN, 0, '0, '0);

      for (int phase = 0; phase < 8; phase++) begin
         ic = $urandom_range(1, 8);
         ks = $urandom_range(1, 4);
         oc = $urandom_range(1, 8);
         set_config(ic, ks, oc, $urandom_range(0, 31), $urandom_range(0, 31));
         sender_idles <= (phase % 4 == 1) || (phase % 4 == 3);
         receiver_stalls <= (phase % 4 == 2) || (phase % 4 == 3);
         idle_pct <= (phase % 4 == 3) ? 20 : 81;
         for (int n = 0; n < 7; n++) random_beat(ic * ks);
      end

      drain();
      if (sb.errors == 0) begin
         $display("binary_conv1d_xnor_popcount_tb: PASS");
      end else begin
         $display("binary_conv1d_xnor_popcount_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("binary_conv1d_xnor_popcount_tb: FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/bcx_pkg.sv
rtl/bcx_ram.sv
rtl/bcx_front.sv
rtl/bcx_back.sv
rtl/binary_conv1d_xnor_popcount.sv
rtl/bcx_checker.sv
test/binary_conv1d_xnor_popcount_tb.sv
